@@ sv/pes_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_pkg
// Widths, reset values, codes and helper functions shared by the position
// error statistics block, its channels and its checker.
// ----------------------------------------------------------------------------
package pes_pkg;

  localparam int COUNTER_BITS = 32;

  localparam int StampW   = 48;
  localparam int PosW     = 32;
  localparam int VarW     = 32;
  localparam int WinW     = 24;
  localparam int ThrW     = 31;
  localparam int DistW    = 31;
  localparam int SdW      = 25;
  localparam int SumW     = 64;
  localparam int OutCntW  = 32;
  localparam int DiffW    = 30;
  localparam int ProdW    = 2 * DiffW;
  localparam int RadW     = ProdW + 1;
  localparam int RootSteps = 31;
  localparam int StepW    = 5;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 31;

  localparam logic signed [PosW:0] DSat = (PosW+1)'(1073741823);

  localparam logic [WinW-1:0] WindowRst  = WinW'(20000);
  localparam logic [ThrW-1:0] ThrLowRst  = ThrW'(1000);
  localparam logic [ThrW-1:0] ThrMidRst  = ThrW'(1500);
  localparam logic [ThrW-1:0] ThrHighRst = ThrW'(2000);

  typedef logic [COUNTER_BITS-1:0] pes_cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_ADD,
    ST_ROOT,
    ST_UPDATE
  } pes_state_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TIME_WINDOW,
    REG_THR_LOW,
    REG_THR_MID,
    REG_THR_HIGH
  } pes_reg_t;

  function automatic pes_cnt_t cnt_inc(pes_cnt_t c);
    return (&c) ? c : c + pes_cnt_t'(1);
  endfunction

  function automatic logic [OutCntW-1:0] cnt_out(pes_cnt_t c);
    logic [63:0] w;
    w = 64'(c);
    return w[OutCntW-1:0];
  endfunction

  // saturated |a - b|
  function automatic logic [DiffW-1:0] sat_abs_diff(logic signed [PosW-1:0] a,
                                                     logic signed [PosW-1:0] b);
    logic signed [PosW:0] d;
    logic signed [PosW:0] m;
    d = (PosW+1)'(a) - (PosW+1)'(b);
    m = (d < 0) ? -d : d;
    if (d > DSat || d < -DSat) begin
      return DSat[DiffW-1:0];
    end
    return m[DiffW-1:0];
  endfunction

endpackage

@@ sv/pes_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_in_if
// Input channel: one pair of stamped positions and the second variances.
// ----------------------------------------------------------------------------
interface pes_in_if
  import pes_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [StampW-1:0]      first_stamp;
  logic [StampW-1:0]      second_stamp;
  logic signed [PosW-1:0] first_x;
  logic signed [PosW-1:0] first_y;
  logic signed [PosW-1:0] second_x;
  logic signed [PosW-1:0] second_y;
  logic [VarW-1:0]        second_var_x;
  logic [VarW-1:0]        second_var_y;

  modport source (
    output valid, first_stamp, second_stamp, first_x, first_y,
           second_x, second_y, second_var_x, second_var_y,
    input  ready
  );

  modport sink (
    input  valid, first_stamp, second_stamp, first_x, first_y,
           second_x, second_y, second_var_x, second_var_y,
    output ready
  );
endinterface

@@ sv/pes_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_out_if
// Result channel: distance of one pair and the running statistics.
// ----------------------------------------------------------------------------
interface pes_out_if
  import pes_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  accepted;
  logic [DistW-1:0]      distance;
  logic [OutCntW-1:0]    sample_count;
  logic [SumW-1:0]       distance_sum;
  logic [DistW-1:0]      max_distance;
  logic signed [SdW-1:0] stamp_diff_at_max;
  logic [VarW-1:0]       var_x_at_max;
  logic [VarW-1:0]       var_y_at_max;
  logic [OutCntW-1:0]    over_low_count;
  logic [OutCntW-1:0]    over_mid_count;
  logic [OutCntW-1:0]    over_high_count;

  modport source (
    output valid, accepted, distance, sample_count, distance_sum, max_distance,
           stamp_diff_at_max, var_x_at_max, var_y_at_max, over_low_count,
           over_mid_count, over_high_count,
    input  ready
  );

  modport sink (
    input  valid, accepted, distance, sample_count, distance_sum, max_distance,
           stamp_diff_at_max, var_x_at_max, var_y_at_max, over_low_count,
           over_mid_count, over_high_count,
    output ready
  );
endinterface

@@ sv/position_error_statistics.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_error_statistics
// Windowed position pair distance with running count, sum, peak and
// threshold exceedance statistics, computed by one shared multiplier and a
// bit-serial square root under a small sequencer.
//
//   channel  dir  handshake        payload
//   in_ch    in   valid / ready    stamps, positions, second variances
//   out_ch   out  valid / ready    accepted, distance, statistics
//   cfg_*    in   cfg_we           cfg_index, cfg_data
//
// An accepted pair runs from transfer to ready again through capture,
// difference, three multiply/add steps, 31 square root steps and update.
// A pair outside the window goes through capture, difference and update only.
// Synchronous active-low reset clears statistics and loads register defaults.
// A stalled result holds in the output register; the next input transfer is
// taken meanwhile and its update waits until the result is taken.
// ----------------------------------------------------------------------------
module position_error_statistics
  import pes_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  pes_in_if.sink              in_ch,
  pes_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  pes_state_t state_r, state_nxt;

  logic [WinW-1:0] window_r;
  logic [ThrW-1:0] thr_low_r, thr_mid_r, thr_high_r;

  pes_cnt_t              pair_total_r;
  logic [SumW-1:0]       error_sum_r;
  logic [DistW-1:0]      peak_error_r;
  logic [SdW-1:0]        peak_sd_r;
  logic [VarW-1:0]       peak_var_x_r, peak_var_y_r;
  pes_cnt_t              exc_low_r, exc_mid_r, exc_high_r;

  logic                  out_valid_r;
  logic                  out_acc_r;
  logic [DistW-1:0]      out_dist_r;

  logic [StampW-1:0]      s1_r, s2_r;
  logic signed [PosW-1:0] x1_r, y1_r, x2_r, y2_r;
  logic [VarW-1:0]        vx_r, vy_r;
  logic                   ok_r;
  logic [SdW-1:0]         sd_r;
  logic [DiffW-1:0]       ax_r, ay_r;
  logic [ProdW-1:0]       prod_r;
  logic [RadW-1:0]        rad_r, res_r;
  logic [StepW-1:0]       step_r;

  logic [StampW:0]   sdiff;
  logic [StampW-1:0] smag;
  logic              win_ok;
  logic [DiffW-1:0]  mul_a;
  logic [ProdW-1:0]  mul_p;
  logic [RadW-1:0]   root_bit, root_trial;
  logic              out_free;
  logic [DistW-1:0]  root_dist;
  logic [SumW:0]     sum_ext;

  assign sdiff  = {1'b0, s1_r} - {1'b0, s2_r};
  assign smag   = sdiff[StampW] ? StampW'(-sdiff) : sdiff[StampW-1:0];
  assign win_ok = smag <= StampW'(window_r);

  assign mul_a = (state_r == ST_SQX) ? ax_r : ay_r;
  assign mul_p = ProdW'(mul_a) * ProdW'(mul_a);

  assign root_bit   = RadW'(1) << {step_r, 1'b0};
  assign root_trial = res_r + root_bit;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign root_dist = res_r[DistW-1:0];
  assign sum_ext   = {1'b0, error_sum_r} + (SumW+1)'(root_dist);

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) state_nxt = ST_DIFF;
      end
      ST_DIFF:   state_nxt = win_ok ? ST_SQX : ST_UPDATE;
      ST_SQX:    state_nxt = ST_SQY;
      ST_SQY:    state_nxt = ST_ADD;
      ST_ADD:    state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (step_r == '0) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      window_r     <= WindowRst;
      thr_low_r    <= ThrLowRst;
      thr_mid_r    <= ThrMidRst;
      thr_high_r   <= ThrHighRst;
      pair_total_r <= '0;
      error_sum_r  <= '0;
      peak_error_r <= '0;
      peak_sd_r    <= '0;
      peak_var_x_r <= '0;
      peak_var_y_r <= '0;
      exc_low_r    <= '0;
      exc_mid_r    <= '0;
      exc_high_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (pes_reg_t'(cfg_index))
          REG_TIME_WINDOW: window_r   <= cfg_data[WinW-1:0];
          REG_THR_LOW:     thr_low_r  <= cfg_data[ThrW-1:0];
          REG_THR_MID:     thr_mid_r  <= cfg_data[ThrW-1:0];
          REG_THR_HIGH:    thr_high_r <= cfg_data[ThrW-1:0];
        endcase
      end
      if (out_ch.valid && out_ch.ready && state_r != ST_UPDATE) out_valid_r <= 1'b0;
      if (state_r == ST_UPDATE && out_free) begin
        out_valid_r <= 1'b1;
        if (ok_r) begin
          pair_total_r <= cnt_inc(pair_total_r);
          error_sum_r  <= sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
          if (root_dist > peak_error_r) begin
            peak_error_r <= root_dist;
            peak_sd_r    <= sd_r;
            peak_var_x_r <= vx_r;
            peak_var_y_r <= vy_r;
          end
          if (root_dist > thr_low_r)  exc_low_r  <= cnt_inc(exc_low_r);
          if (root_dist > thr_mid_r)  exc_mid_r  <= cnt_inc(exc_mid_r);
          if (root_dist > thr_high_r) exc_high_r <= cnt_inc(exc_high_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          s1_r <= in_ch.first_stamp;
          s2_r <= in_ch.second_stamp;
          x1_r <= in_ch.first_x;
          y1_r <= in_ch.first_y;
          x2_r <= in_ch.second_x;
          y2_r <= in_ch.second_y;
          vx_r <= in_ch.second_var_x;
          vy_r <= in_ch.second_var_y;
        end
      end
      ST_DIFF: begin
        ok_r   <= win_ok;
        sd_r   <= sdiff[SdW-1:0];
        ax_r   <= sat_abs_diff(x1_r, x2_r);
        ay_r   <= sat_abs_diff(y1_r, y2_r);
        res_r  <= '0;
        step_r <= StepW'(RootSteps - 1);
      end
      ST_SQX: prod_r <= mul_p;
      ST_SQY: begin
        rad_r  <= RadW'(prod_r);
        prod_r <= mul_p;
      end
      ST_ADD: rad_r <= rad_r + RadW'(prod_r);
      ST_ROOT: begin
        if (rad_r >= root_trial) begin
          rad_r <= rad_r - root_trial;
          res_r <= (res_r >> 1) + root_bit;
        end else begin
          res_r <= res_r >> 1;
        end
        step_r <= step_r - StepW'(1);
      end
      ST_UPDATE: begin
        if (out_free) begin
          out_acc_r  <= ok_r;
          out_dist_r <= root_dist;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.accepted          = out_acc_r;
  assign out_ch.distance          = out_dist_r;
  assign out_ch.sample_count      = cnt_out(pair_total_r);
  assign out_ch.distance_sum      = error_sum_r;
  assign out_ch.max_distance      = peak_error_r;
  assign out_ch.stamp_diff_at_max = peak_sd_r;
  assign out_ch.var_x_at_max      = peak_var_x_r;
  assign out_ch.var_y_at_max      = peak_var_y_r;
  assign out_ch.over_low_count    = cnt_out(exc_low_r);
  assign out_ch.over_mid_count    = cnt_out(exc_mid_r);
  assign out_ch.over_high_count   = cnt_out(exc_high_r);

endmodule

@@ sv/pes_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_checker
// Port-level checks on the position error statistics block, bound to it.
// ----------------------------------------------------------------------------
module pes_checker
  import pes_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             accepted,
  input logic [DistW-1:0] distance,
  input logic [DistW-1:0] max_distance
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(distance) && $stable(accepted))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !accepted |-> distance == '0)
    else $error("rejected pair with nonzero distance");

  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && accepted |-> max_distance >= distance)
    else $error("peak below delivered distance");

endmodule

bind position_error_statistics pes_checker u_pes_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .accepted     (out_ch.accepted),
  .distance     (out_ch.distance),
  .max_distance (out_ch.max_distance)
);
